// ===== hw/rtl/skvt_pkg.sv =====
`timescale 1ns / 1ps

package skvt_pkg;

    // Request codes carried on the request word's type field
    typedef enum logic [2:0] {
        REQ_INSERT     = 3'd0,
        REQ_UPDATE     = 3'd1,
        REQ_INS_OR_UPD = 3'd2,
        REQ_ERASE      = 3'd3,
        REQ_LOOKUP     = 3'd4,
        REQ_READ_POS   = 3'd5
    } t_req_type;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic capture;  // latch compare flags against the incoming word
        logic ins;      // open a gap at the insert point, shift upwards
        logic del;      // close the gap at the hit, shift downwards
        logic upd;      // overwrite the value of the hit cell
    } t_cell_ctrl;

    localparam int TYPE_W  = 3;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 9;

endpackage

// ===== hw/rtl/sorted_key_value_table_top.sv =====
`timescale 1ns / 1ps

// Sorted key/value table built as a chain of cells, one pair per cell, ascending keys.
// Request channel (i_req_*): valid/ready; type, key, value and position in one word.
// Response channel (o_rsp_*): valid/ready; ok flag, key, value and entry count.
// Each request has a compare step and an execute step: at the accepting edge every
// cell compares its key with the request key (or its index with the position) and
// latches the flags; when the execute step fires, the chain shifts, updates or
// is read and the response register loads, raising o_rsp_valid. A new word is
// not accepted until the previous one has executed, since the next compare must
// see the shifted chain.
// If the receiver stalls, one further word is accepted and held in the execute
// step, with ready low, until the response register frees.
// Reset (synchronous, active low) clears the entry count and the handshake
// state; cell contents are meaningless until written and are never read
// beyond the count.
module sorted_key_value_table_top #(
    parameter int CAPACITY   = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  logic [skvt_pkg::TYPE_W-1:0]     i_req_type,
    input  logic [skvt_pkg::KEY_W-1:0]      i_req_key,
    input  logic [skvt_pkg::VALUE_W-1:0]    i_req_value,
    input  logic [skvt_pkg::POS_W-1:0]      i_req_position,
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_ready,
    output logic                            o_ok,
    output logic [skvt_pkg::KEY_W-1:0]      o_out_key,
    output logic [skvt_pkg::VALUE_W-1:0]    o_out_value,
    output logic [skvt_pkg::COUNT_W-1:0]    o_entry_count
);

    // stored widths: the port carries 32 bits, so keys/values never exceed that
    localparam int KW = (KEY_BITS   < skvt_pkg::KEY_W)   ? KEY_BITS   : skvt_pkg::KEY_W;
    localparam int VW = (VALUE_BITS < skvt_pkg::VALUE_W) ? VALUE_BITS : skvt_pkg::VALUE_W;
    localparam int CW = $clog2(CAPACITY + 1);

    // handshake / sequencing
    skvt_pkg::t_state r_state, n_state;
    logic             accept;
    logic             fire;

    // latched request word
    logic [skvt_pkg::TYPE_W-1:0]  r_type;
    logic [skvt_pkg::KEY_W-1:0]   r_key;
    logic [VW-1:0]                r_value;

    // table occupancy
    logic [CW-1:0] r_count, n_count;

    // response register
    logic                           r_rsp_valid, n_rsp_valid;
    logic                           r_ok, n_ok;
    logic [skvt_pkg::KEY_W-1:0]     r_out_key, n_out_key;
    logic [skvt_pkg::VALUE_W-1:0]   r_out_value, n_out_value;
    logic [CW-1:0]                  r_rsp_count;

    // chain wiring
    skvt_pkg::t_cell_ctrl cell_ctrl;
    logic [KW-1:0] cell_key   [CAPACITY];
    logic [VW-1:0] cell_value [CAPACITY];
    logic          cell_lt    [CAPACITY];
    logic          cell_eq    [CAPACITY];

    // reductions over the chain
    logic          hit;
    logic [KW-1:0] rd_key;
    logic [VW-1:0] rd_value;
    logic          full;
    logic          do_ins, do_del, do_upd;

    assign accept = i_req_valid && o_req_ready;
    assign fire   = (r_state == skvt_pkg::ST_EXEC) && (!r_rsp_valid || i_rsp_ready);
    assign full   = r_count >= CW'(CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skvt_pkg::ST_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        unique case (r_state)
            skvt_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_state = skvt_pkg::ST_EXEC;
                end
            end
            skvt_pkg::ST_EXEC: begin
                // wait here while the previous response is still unclaimed
                if (fire) begin
                    n_state = skvt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = skvt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type  <= i_req_type;
            r_key   <= i_req_key;
            r_value <= VW'(i_req_value);
        end
        if (fire) begin
            r_ok        <= n_ok;
            r_out_key   <= n_out_key;
            r_out_value <= n_out_value;
            r_rsp_count <= n_count;
        end
    end

    // hit flag and one-hot read of the matching cell
    always_comb begin
        hit      = 1'b0;
        rd_key   = '0;
        rd_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit      = hit | cell_eq[i];
            rd_key   = rd_key   | (cell_key[i]   & {KW{cell_eq[i]}});
            rd_value = rd_value | (cell_value[i] & {VW{cell_eq[i]}});
        end
    end

    // operation decode for the execute step
    always_comb begin
        do_ins      = 1'b0;
        do_del      = 1'b0;
        do_upd      = 1'b0;
        n_ok        = 1'b0;
        n_out_key   = r_key;
        n_out_value = '0;
        unique case (r_type)
            skvt_pkg::REQ_INSERT: begin
                // a full table refuses even a duplicate key
                do_ins = !full && !hit;
                n_ok   = do_ins;
            end
            skvt_pkg::REQ_UPDATE: begin
                do_upd = hit;
                n_ok   = hit;
            end
            skvt_pkg::REQ_INS_OR_UPD: begin
                do_upd = hit;
                do_ins = !hit && !full;
                n_ok   = do_upd || do_ins;
            end
            skvt_pkg::REQ_ERASE: begin
                do_del = hit;
                n_ok   = hit;
            end
            skvt_pkg::REQ_LOOKUP: begin
                n_ok = hit;
                if (hit) begin
                    n_out_value = skvt_pkg::VALUE_W'(rd_value);
                end
            end
            skvt_pkg::REQ_READ_POS: begin
                n_ok = hit;
                if (hit) begin
                    n_out_key   = skvt_pkg::KEY_W'(rd_key);
                    n_out_value = skvt_pkg::VALUE_W'(rd_value);
                end
            end
            default: begin
                // unused codes: echo the key, report failure
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (fire && do_ins) begin
            n_count = r_count + CW'(1);
        end else if (fire && do_del) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (fire) begin
            n_rsp_valid = 1'b1;
        end else if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    assign cell_ctrl.capture = accept;
    assign cell_ctrl.ins     = fire && do_ins;
    assign cell_ctrl.del     = fire && do_del;
    assign cell_ctrl.upd     = fire && do_upd;

    // the chain: each cell sees its left and right neighbour
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic          prev_lt;
        logic [KW-1:0] prev_key, next_key;
        logic [VW-1:0] prev_value, next_value;

        if (g == 0) begin : g_first
            // nothing lies below the first slot
            assign prev_lt    = 1'b1;
            assign prev_key   = '0;
            assign prev_value = '0;
        end else begin : g_mid
            assign prev_lt    = cell_lt[g-1];
            assign prev_key   = cell_key[g-1];
            assign prev_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_key   = cell_key[g];
            assign next_value = cell_value[g];
        end else begin : g_inner
            assign next_key   = cell_key[g+1];
            assign next_value = cell_value[g+1];
        end

        skvt_cell #(
            .INDEX (g),
            .KW    (KW),
            .VW    (VW),
            .CW    (CW)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctrl         (cell_ctrl),
            .i_cmp_key      (KW'(i_req_key)),
            .i_use_pos      (i_req_type == skvt_pkg::REQ_READ_POS),
            .i_req_position (i_req_position),
            .i_count        (r_count),
            .i_wr_key       (KW'(r_key)),
            .i_wr_value     (r_value),
            .i_prev_lt      (prev_lt),
            .i_prev_key     (prev_key),
            .i_prev_value   (prev_value),
            .i_next_key     (next_key),
            .i_next_value   (next_value),
            .o_key          (cell_key[g]),
            .o_value        (cell_value[g]),
            .o_lt           (cell_lt[g]),
            .o_eq           (cell_eq[g])
        );
    end

    assign o_rsp_valid   = r_rsp_valid;
    assign o_ok          = r_ok;
    assign o_out_key     = r_out_key;
    assign o_out_value   = r_out_value;
    assign o_entry_count = skvt_pkg::COUNT_W'(r_rsp_count);

endmodule

// ===== hw/rtl/skvt_cell.sv =====
`timescale 1ns / 1ps

// One slot of the sorted chain: a key/value pair plus its compare flags.
module skvt_cell #(
    parameter int INDEX = 0,
    parameter int KW    = 32,
    parameter int VW    = 32,
    parameter int CW    = 9
) (
    input  logic                 i_clk,
    input  skvt_pkg::t_cell_ctrl i_ctrl,
    input  logic [KW-1:0]        i_cmp_key,
    input  logic                 i_use_pos,
    input  logic [skvt_pkg::POS_W-1:0] i_req_position,
    input  logic [CW-1:0]        i_count,
    input  logic [KW-1:0]        i_wr_key,
    input  logic [VW-1:0]        i_wr_value,
    input  logic                 i_prev_lt,
    input  logic [KW-1:0]        i_prev_key,
    input  logic [VW-1:0]        i_prev_value,
    input  logic [KW-1:0]        i_next_key,
    input  logic [VW-1:0]        i_next_value,
    output logic [KW-1:0]        o_key,
    output logic [VW-1:0]        o_value,
    output logic                 o_lt,
    output logic                 o_eq
);

    localparam int PW = (CW > skvt_pkg::POS_W) ? CW : skvt_pkg::POS_W;

    logic [KW-1:0] r_key, n_key;
    logic [VW-1:0] r_value, n_value;
    logic          r_lt, n_lt;
    logic          r_eq, n_eq;
    logic          occupied;
    logic          pos_match;

    assign occupied  = CW'(INDEX) < i_count;
    assign pos_match = PW'(INDEX) == PW'(i_req_position);

    always_comb begin
        n_lt = r_lt;
        n_eq = r_eq;
        if (i_ctrl.capture) begin
            n_lt = occupied && !i_use_pos && (r_key < i_cmp_key);
            n_eq = occupied && (i_use_pos ? pos_match : (r_key == i_cmp_key));
        end
    end

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        priority if (i_ctrl.ins && !r_lt) begin
            // insert point is the first cell whose left neighbour is still lower
            n_key   = i_prev_lt ? i_wr_key   : i_prev_key;
            n_value = i_prev_lt ? i_wr_value : i_prev_value;
        end else if (i_ctrl.del && !r_lt) begin
            n_key   = i_next_key;
            n_value = i_next_value;
        end else if (i_ctrl.upd && r_eq) begin
            n_value = i_wr_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        r_lt    <= n_lt;
        r_eq    <= n_eq;
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

// ===== dv/sorted_key_value_table_top_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the sorted key/value table. A shadow copy of the
// table is kept here. Every request word is applied to that copy at the edge it
// is accepted, and the word the block should return is queued. Response words
// are compared field by field, in order, against that queue.
module sorted_key_value_table_top_tb;

    localparam int CAPACITY   = 256;
    localparam int HOLD_LONG  = 300;   // cycles of the long receiver hold-off
    localparam int IDLE_LIMIT = 1500;  // cycles with no handshake before giving up
    localparam int DRAIN_WAIT = 20;    // settling cycles once nothing is owed

    localparam int TYPE_W  = skvt_pkg::TYPE_W;
    localparam int KEY_W   = skvt_pkg::KEY_W;
    localparam int VALUE_W = skvt_pkg::VALUE_W;
    localparam int POS_W   = skvt_pkg::POS_W;
    localparam int COUNT_W = skvt_pkg::COUNT_W;

    // Type codes outside the enum: the block must ignore them
    localparam logic [TYPE_W-1:0] REQ_RSVD_6 = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_RSVD_7 = 3'd7;

    typedef struct packed {
        logic               ok;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } t_rsp_word;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_req_valid    = 1'b0;
    logic                 o_req_ready;
    logic [TYPE_W-1:0]    i_req_type     = '0;
    logic [KEY_W-1:0]     i_req_key      = '0;
    logic [VALUE_W-1:0]   i_req_value    = '0;
    logic [POS_W-1:0]     i_req_position = '0;
    logic                 o_rsp_valid;
    logic                 i_rsp_ready    = 1'b0;
    logic                 o_ok;
    logic [KEY_W-1:0]     o_out_key;
    logic [VALUE_W-1:0]   o_out_value;
    logic [COUNT_W-1:0]   o_entry_count;

    // Shadow table: ascending keys, entries below shadow_count are live
    logic [KEY_W-1:0]     shadow_keys   [CAPACITY];
    logic [VALUE_W-1:0]   shadow_values [CAPACITY];
    int                   shadow_count = 0;

    t_rsp_word            rsp_owed[$];   // words the block still has to return
    t_rsp_word            rsp_want;
    int                   err_cnt    = 0;
    int                   rsp_seen   = 0;

    // Sender pacing
    int                   burst_left = 1;
    bit                   steady_send = 1'b0;  // no gaps while set

    // Receiver pacing
    int                   hold_asked = 0;
    int                   hold_done  = 0;
    int                   hold_left  = 0;
    int                   rsp_mode   = 0;
    int                   rsp_age    = 0;
    logic [7:0]           rsp_pattern = 8'b1011_0010;

    int                   idle_cycles = 0;

    sorted_key_value_table_top #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_W),
        .VALUE_BITS (VALUE_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req_valid),
        .o_req_ready    (o_req_ready),
        .i_req_type     (i_req_type),
        .i_req_key      (i_req_key),
        .i_req_value    (i_req_value),
        .i_req_position (i_req_position),
        .o_rsp_valid    (o_rsp_valid),
        .i_rsp_ready    (i_rsp_ready),
        .o_ok           (o_ok),
        .o_out_key      (o_out_key),
        .o_out_value    (o_out_value),
        .o_entry_count  (o_entry_count)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------

    // Open a gap at slot and place the pair there; refuses on a full table
    // or when the key is already held.
    function automatic bit shadow_insert(input int slot, input bit hit,
                                         input logic [KEY_W-1:0] key,
                                         input logic [VALUE_W-1:0] val);
        if (shadow_count >= CAPACITY || hit)
            return 1'b0;
        for (int i = shadow_count; i > slot; i--) begin
            shadow_keys[i]   = shadow_keys[i-1];
            shadow_values[i] = shadow_values[i-1];
        end
        shadow_keys[slot]   = key;
        shadow_values[slot] = val;
        shadow_count++;
        return 1'b1;
    endfunction

    // Apply one request to the shadow table and give the word it returns
    function automatic t_rsp_word table_apply(input logic [TYPE_W-1:0] op,
                                              input logic [KEY_W-1:0] key,
                                              input logic [VALUE_W-1:0] val,
                                              input logic [POS_W-1:0] pos);
        t_rsp_word r;
        int        slot;
        bit        hit;
        r.ok    = 1'b0;
        r.key   = key;
        r.value = '0;
        // first slot whose key is not below the request key
        slot = 0;
        while (slot < shadow_count && shadow_keys[slot] < key)
            slot++;
        hit = (slot < shadow_count) && (shadow_keys[slot] == key);
        case (op)
            skvt_pkg::REQ_INSERT: begin
                r.ok = shadow_insert(slot, hit, key, val);
            end
            skvt_pkg::REQ_UPDATE, skvt_pkg::REQ_INS_OR_UPD: begin
                if (hit) begin
                    shadow_values[slot] = val;
                    r.ok = 1'b1;
                end else if (op == skvt_pkg::REQ_INS_OR_UPD) begin
                    r.ok = shadow_insert(slot, hit, key, val);
                end
            end
            skvt_pkg::REQ_ERASE: begin
                if (hit) begin
                    for (int i = slot; i + 1 < shadow_count; i++) begin
                        shadow_keys[i]   = shadow_keys[i+1];
                        shadow_values[i] = shadow_values[i+1];
                    end
                    shadow_count--;
                    r.ok = 1'b1;
                end
            end
            skvt_pkg::REQ_LOOKUP: begin
                if (hit) begin
                    r.ok    = 1'b1;
                    r.value = shadow_values[slot];
                end
            end
            skvt_pkg::REQ_READ_POS: begin
                if (pos < shadow_count) begin
                    r.ok    = 1'b1;
                    r.key   = shadow_keys[pos];
                    r.value = shadow_values[pos];
                end
            end
            default: ;  // reserved codes change nothing
        endcase
        r.count = shadow_count[COUNT_W-1:0];
        return r;
    endfunction

    // Key chooser: mostly keys that are held, else a small crowded range,
    // the two extremes, or anything at all.
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5 && shadow_count > 0)
            return shadow_keys[$urandom_range(0, shadow_count - 1)];
        if (sel < 7)
            return $urandom_range(0, 63);
        if (sel == 7)
            return $urandom_range(0, 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
        return $urandom();
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one word and hold it until taken. Valid is only dropped at the end
    // of a burst; otherwise the next call reloads the payload in the same step.
    task automatic send_req(input logic [TYPE_W-1:0] op, input logic [KEY_W-1:0] key,
                            input logic [VALUE_W-1:0] val, input logic [POS_W-1:0] pos);
        int gap;
        i_req_type     <= op;
        i_req_key      <= key;
        i_req_value    <= val;
        i_req_position <= pos;
        i_req_valid    <= 1'b1;
        @(posedge i_clk);
        while (!o_req_ready)
            @(posedge i_clk);
        rsp_owed.push_back(table_apply(op, key, val, pos));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 && !steady_send) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Edges of every field, every request code, the named corner cases
    task automatic test_directed();
        send_req(skvt_pkg::REQ_LOOKUP,     32'h0000_0000, 32'h1111_1111, 8'h00); // empty
        send_req(skvt_pkg::REQ_READ_POS,   32'h0BAD_0BAD, 32'h0,         8'h00); // none at 0
        send_req(skvt_pkg::REQ_ERASE,      32'h0000_0005, 32'h0,         8'hFF);
        send_req(skvt_pkg::REQ_UPDATE,     32'h0000_0005, 32'hDEAD_BEEF, 8'h00);
        send_req(skvt_pkg::REQ_INSERT,     32'h0000_0000, 32'hFFFF_FFFF, 8'h00);
        send_req(skvt_pkg::REQ_INSERT,     32'hFFFF_FFFF, 32'h0000_0000, 8'hFF);
        send_req(skvt_pkg::REQ_INSERT,     32'h0000_0000, 32'h1234_5678, 8'h00); // duplicate
        send_req(skvt_pkg::REQ_INS_OR_UPD, 32'hFFFF_FFFF, 32'h1234_5678, 8'h00); // update
        send_req(skvt_pkg::REQ_INS_OR_UPD, 32'h8000_0000, 32'h5555_5555, 8'h00); // insert
        send_req(skvt_pkg::REQ_INSERT,     32'h7FFF_FFFF, 32'hAAAA_AAAA, 8'h00); // mid
        send_req(skvt_pkg::REQ_UPDATE,     32'h0000_0000, 32'hA5A5_A5A5, 8'h00);
        send_req(skvt_pkg::REQ_LOOKUP,     32'hFFFF_FFFF, 32'h0,         8'h00);
        send_req(skvt_pkg::REQ_READ_POS,   32'h0,         32'h0,         8'h00);
        send_req(skvt_pkg::REQ_READ_POS,   32'h0,         32'h0,         8'h01);
        send_req(skvt_pkg::REQ_READ_POS,   32'h0,         32'h0,         8'h03);
        send_req(skvt_pkg::REQ_READ_POS,   32'hCAFE_F00D, 32'h0,         8'h04); // at count
        send_req(skvt_pkg::REQ_READ_POS,   32'h5A5A_5A5A, 32'h0,         8'hFF);
        send_req(REQ_RSVD_6,               32'h8000_0000, 32'hFFFF_FFFF, 8'h01);
        send_req(REQ_RSVD_7,               32'h0000_0000, 32'hFFFF_FFFF, 8'h00);
        send_req(skvt_pkg::REQ_ERASE,      32'h8000_0000, 32'h0,         8'h00); // middle
        send_req(skvt_pkg::REQ_ERASE,      32'h0000_0000, 32'h0,         8'h00); // first
        send_req(skvt_pkg::REQ_ERASE,      32'hFFFF_FFFF, 32'h0,         8'h00); // last
        send_req(skvt_pkg::REQ_ERASE,      32'hFFFF_FFFF, 32'h0,         8'h00); // absent
        send_req(skvt_pkg::REQ_LOOKUP,     32'h8000_0000, 32'h0,         8'h00);
        send_req(skvt_pkg::REQ_READ_POS,   32'h0,         32'h0,         8'h00);
    endtask

    // Grow the table to capacity with wide-ranging keys
    task automatic test_fill();
        int sel;
        while (shadow_count < CAPACITY) begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                send_req(skvt_pkg::REQ_INSERT, $urandom(), $urandom(),
                         POS_W'($urandom_range(0, 255)));
            else if (sel == 7)
                send_req(skvt_pkg::REQ_INS_OR_UPD, pick_key(), $urandom(),
                         POS_W'($urandom_range(0, 255)));
            else if (sel == 8)
                send_req(skvt_pkg::REQ_LOOKUP, pick_key(), $urandom(),
                         POS_W'($urandom_range(0, 255)));
            else
                send_req(skvt_pkg::REQ_READ_POS, $urandom(), $urandom(),
                         POS_W'($urandom_range(0, 255)));
        end
    endtask

    // Full table: inserts refused even for held keys, insert-or-update only
    // updates, the top position is readable. Refill after the odd erase.
    task automatic test_full();
        logic [TYPE_W-1:0] op;
        repeat (70) begin
            if (shadow_count < CAPACITY && $urandom_range(0, 1))
                op = skvt_pkg::REQ_INSERT;
            else
                op = TYPE_W'($urandom_range(0, 7));
            send_req(op, $urandom_range(0, 1) ? pick_key() : $urandom(), $urandom(),
                     $urandom_range(0, 3) == 0 ? 8'hFF : POS_W'($urandom_range(0, 255)));
        end
    endtask

    // Empty the table again, mostly by erasing held keys
    task automatic test_drain();
        int sel;
        while (shadow_count > 0) begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                send_req(skvt_pkg::REQ_ERASE, shadow_keys[$urandom_range(0, shadow_count - 1)],
                         $urandom(), POS_W'($urandom_range(0, 255)));
            else if (sel == 6)
                send_req(skvt_pkg::REQ_ERASE, $urandom(), $urandom(),
                         POS_W'($urandom_range(0, 255)));
            else if (sel == 7)
                send_req(skvt_pkg::REQ_READ_POS, $urandom(), $urandom(),
                         POS_W'($urandom_range(0, 255)));
            else if (sel == 8)
                send_req(skvt_pkg::REQ_LOOKUP, pick_key(), $urandom(),
                         POS_W'($urandom_range(0, 255)));
            else
                send_req(skvt_pkg::REQ_UPDATE, pick_key(), $urandom(),
                         POS_W'($urandom_range(0, 255)));
        end
    endtask

    // Mixed traffic on a crowded key range, so hits and misses both happen
    task automatic test_random_mix();
        int                sel;
        logic [TYPE_W-1:0] op;
        logic [POS_W-1:0]  pos;
        repeat (225) begin
            sel = $urandom_range(0, 99);
            if      (sel < 25) op = skvt_pkg::REQ_INSERT;
            else if (sel < 35) op = skvt_pkg::REQ_UPDATE;
            else if (sel < 50) op = skvt_pkg::REQ_INS_OR_UPD;
            else if (sel < 70) op = skvt_pkg::REQ_ERASE;
            else if (sel < 82) op = skvt_pkg::REQ_LOOKUP;
            else if (sel < 95) op = skvt_pkg::REQ_READ_POS;
            else               op = $urandom_range(0, 1) ? REQ_RSVD_6 : REQ_RSVD_7;
            pos = $urandom_range(0, 3) == 0 ? POS_W'($urandom_range(0, 255))
                                            : POS_W'($urandom_range(0, shadow_count + 3));
            send_req(op, pick_key(), $urandom(), pos);
        end
    endtask

    // Receiver goes quiet for a long stretch while words keep coming, so the
    // block fills up and drops its ready
    task automatic test_backpressure();
        steady_send = 1'b1;
        hold_asked++;
        repeat (30)
            send_req(TYPE_W'($urandom_range(0, 5)), pick_key(), $urandom(),
                     POS_W'($urandom_range(0, 255)));
        steady_send = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill();
        test_full();
        test_drain();
        test_random_mix();
        test_backpressure();
        test_random_mix();

        i_req_valid <= 1'b0;
        while (rsp_owed.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0)
            $display("sorted_key_value_table_top test passed");
        else
            $display("sorted_key_value_table_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    // Stall pattern changes every so often: always ready, coin toss, mostly
    // stalled, or a rotating bit pattern. A requested hold-off overrides it.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_rsp_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_done != hold_asked) begin
            i_rsp_ready <= 1'b0;
            hold_done = hold_done + 1;
            hold_left = HOLD_LONG;
        end else begin
            if (rsp_age == 0) begin
                rsp_mode    = $urandom_range(0, 3);
                rsp_pattern = 8'($urandom());
                rsp_age     = $urandom_range(20, 120);
            end else begin
                rsp_age = rsp_age - 1;
            end
            case (rsp_mode)
                0:       i_rsp_ready <= 1'b1;
                1:       i_rsp_ready <= 1'($urandom_range(0, 1));
                2:       i_rsp_ready <= ($urandom_range(0, 3) == 0);
                default: i_rsp_ready <= rsp_pattern[rsp_age % 8];
            endcase
        end
    end

    task report_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("ERROR @%0t response %0d %s: expected %h, got %h",
                 $time, rsp_seen, what, want, got);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (rsp_owed.size() == 0) begin
                report_mismatch("unexpected word, key", '0, o_out_key);
            end else begin
                rsp_want = rsp_owed.pop_front();
                if (o_ok !== rsp_want.ok)
                    report_mismatch("ok", 32'(rsp_want.ok), 32'(o_ok));
                if (o_out_key !== rsp_want.key)
                    report_mismatch("key", rsp_want.key, o_out_key);
                if (o_out_value !== rsp_want.value)
                    report_mismatch("value", rsp_want.value, o_out_value);
                if (o_entry_count !== rsp_want.count)
                    report_mismatch("entry count", 32'(rsp_want.count), 32'(o_entry_count));
            end
            rsp_seen++;
        end
    end

    // Watchdog: too long without any handshake on either side means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
                $display("sorted_key_value_table_top test failed");
                $finish;
            end
        end
    end

endmodule

// ===== sorted_key_value_table_top.f =====
hw/rtl/skvt_pkg.sv
hw/rtl/skvt_cell.sv
hw/rtl/sorted_key_value_table_top.sv
dv/sorted_key_value_table_top_tb.sv
